>>> hdl/ipid_pkg.sv
`default_nettype none

package ipid_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int ZONE_W    = 31;
	localparam int CFG_IDX_W = 3;

	// one turn and half a turn in degrees, scaled to the fixed-point format
	localparam logic [63:0] FULL_TURN = 64'd360 << FRAC_BITS;
	localparam logic [63:0] HALF_TURN = 64'd180 << FRAC_BITS;

	// reciprocal of a full turn for the quotient estimate, off by at most one
	localparam int          RECIP_SHIFT = 40;
	localparam logic [63:0] RECIP       = (64'd1 << RECIP_SHIFT) / FULL_TURN;
	localparam int          RECIP_W     = $clog2(RECIP + 64'd1);
	localparam int          PROD_W      = DATA_W + RECIP_W;
	localparam int          QUO_W       = $clog2(((64'd1 << DATA_W) / FULL_TURN) + 64'd2);
	localparam int          WRAP_W      = 35;

	localparam logic [ZONE_W-1:0]        RST_LIMIT   = 31'd65536000;
	localparam logic signed [DATA_W-1:0] RST_OUT_MAX = 32'sd65536000;
	localparam logic signed [DATA_W-1:0] RST_OUT_MIN = -32'sd65536000;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_ANGLE,
		KIND_ANTIWINDUP,
		KIND_CLEAR
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_INTEG_BOUND,
		REG_OUTPUT_MAX,
		REG_OUTPUT_MIN,
		REG_ERROR_ZONE,
		REG_OUTPUT_ZONE
	} cfg_reg_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [DATA_W-1:0]   setpoint;
		logic signed [DATA_W-1:0]   feedback;
	} in_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]   drive;
		logic signed [DATA_W-1:0]   error_used;
		logic                       clamped;
	} out_rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]   gain_p;
		logic signed [DATA_W-1:0]   gain_i;
		logic signed [DATA_W-1:0]   gain_d;
		logic [ZONE_W-1:0]          integ_bound;
		logic signed [DATA_W-1:0]   output_max;
		logic signed [DATA_W-1:0]   output_min;
		logic [ZONE_W-1:0]          error_zone;
		logic [ZONE_W-1:0]          output_zone;
	} cfg_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [DATA_W-1:0]   err;
	} err_item_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [DATA_W-1:0]   err;
		logic signed [DATA_W+1:0]   pd;
		logic signed [DATA_W+2:0]   pdi;
		logic signed [DATA_W-1:0]   di;
	} inc_item_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT_HI) begin
			r = DATA_W'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = DATA_W'(SAT_LO);
		end else begin
			r = DATA_W'(v);
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] v);
		return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
	endfunction

	// arithmetic shift floors toward minus infinity
	function automatic logic signed [DATA_W-1:0] scale(input logic signed [63:0] p);
		return sat32(p >>> FRAC_BITS);
	endfunction

endpackage

`default_nettype wire

>>> hdl/ipid_error.sv
`default_nettype none

module ipid_error import ipid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  in_req_t   up_req,
	input  cfg_t      cfg,
	output logic      dn_valid,
	input  logic      dn_ready,
	output err_item_t dn_item
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	in_req_t                  req_s1;
	kind_t                    kind_s2, kind_s3;
	logic signed [DATA_W:0]   raw_s2, raw_s3;
	logic [DATA_W-1:0]        mag_s2;
	logic [QUO_W-1:0]         quo_s2;
	logic [DATA_W-1:0]        rem_s3;
	err_item_t                item_s4;

	logic signed [DATA_W:0]   raw_c;
	logic [DATA_W-1:0]        mag_c;
	logic [PROD_W-1:0]        recip_prod;
	logic [QUO_W-1:0]         quo_c;
	logic [63:0]              turns;
	logic [DATA_W-1:0]        rem0;
	logic [DATA_W-1:0]        rem_c;
	logic signed [WRAP_W-1:0] half_s, full_s;
	logic signed [WRAP_W-1:0] rem_ext, rem_sgn, wrap1, wrap2, val;
	logic signed [DATA_W-1:0] err_sat, err_c;

	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;
	assign dn_valid = v_s4;
	assign dn_item  = item_s4;

	// stage 2: raw difference and quotient estimate by reciprocal
	always_comb begin
		raw_c      = (DATA_W+1)'(req_s1.setpoint) - (DATA_W+1)'(req_s1.feedback);
		mag_c      = raw_c[DATA_W] ? DATA_W'(-raw_c) : DATA_W'(raw_c);
		recip_prod = PROD_W'(mag_c) * PROD_W'(RECIP);
		quo_c      = QUO_W'(recip_prod >> RECIP_SHIFT);
	end

	// stage 3: remainder of the magnitude, one correction step
	always_comb begin
		turns = 64'(quo_s2) * FULL_TURN;
		rem0  = DATA_W'(64'(mag_s2) - turns);
		rem_c = (64'(rem0) >= FULL_TURN) ? DATA_W'(64'(rem0) - FULL_TURN) : rem0;
	end

	// stage 4: sign of the remainder follows the difference, fold angle requests into (-half, half]
	always_comb begin
		half_s  = $signed(WRAP_W'(HALF_TURN));
		full_s  = $signed(WRAP_W'(FULL_TURN));
		rem_ext = $signed({3'b000, rem_s3});
		rem_sgn = raw_s3[DATA_W] ? -rem_ext : rem_ext;
		wrap1   = (rem_sgn > half_s) ? rem_sgn - full_s : rem_sgn;
		wrap2   = (wrap1 <= -half_s) ? wrap1 + full_s : wrap1;
		val     = (kind_s3 == KIND_ANGLE) ? wrap2 : WRAP_W'(raw_s3);
		err_sat = sat32(64'(val));
		err_c   = (abs32(err_sat) < {1'b0, cfg.error_zone}) ? '0 : err_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && rdy_s1) begin
			req_s1 <= up_req;
		end
		if (v_s1 && rdy_s2) begin
			kind_s2 <= req_s1.kind;
			raw_s2  <= raw_c;
			mag_s2  <= mag_c;
			quo_s2  <= quo_c;
		end
		if (v_s2 && rdy_s3) begin
			kind_s3 <= kind_s2;
			raw_s3  <= raw_s2;
			rem_s3  <= rem_c;
		end
		if (v_s3 && rdy_s4) begin
			item_s4.kind <= kind_s3;
			item_s4.err  <= err_c;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ipid_gain.sv
`default_nettype none

module ipid_gain import ipid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  err_item_t up_item,
	input  cfg_t      cfg,
	output logic      dn_valid,
	input  logic      dn_ready,
	output inc_item_t dn_item
);

	logic v_s5, v_s6, v_s7;
	logic rdy_s5, rdy_s6, rdy_s7;
	logic take_s5;

	// error history, moves with each item entering stage 5 and is zeroed by a clear item
	logic signed [DATA_W-1:0] e1_q, e2_q;

	kind_t                    kind_s5, kind_s6;
	logic signed [DATA_W-1:0] err_s5, err_s6;
	logic signed [DATA_W-1:0] dpe_s5, dde_s5;
	logic signed [63:0]       pp_s6, pi_s6, pd_s6;
	inc_item_t                item_s7;

	logic signed [DATA_W-1:0] dpe_c, dde_c;
	logic signed [63:0]       pp_c, pi_c, pd_c;
	logic signed [DATA_W-1:0] dp_c, di_c, dd_c;
	logic signed [DATA_W+1:0] pdsum_c;
	logic signed [DATA_W+2:0] pdi_c;

	assign rdy_s7   = !v_s7 || dn_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign up_ready = rdy_s5;
	assign take_s5  = up_valid && rdy_s5;
	assign dn_valid = v_s7;
	assign dn_item  = item_s7;

	always_comb begin
		dpe_c = sat32(64'(up_item.err) - 64'(e1_q));
		dde_c = sat32(64'(up_item.err) - (64'(e1_q) <<< 1) + 64'(e2_q));
	end

	always_comb begin
		pp_c = 64'(cfg.gain_p) * 64'(dpe_s5);
		pi_c = 64'(cfg.gain_i) * 64'(err_s5);
		pd_c = 64'(cfg.gain_d) * 64'(dde_s5);
	end

	always_comb begin
		dp_c    = scale(pp_s6);
		di_c    = scale(pi_s6);
		dd_c    = scale(pd_s6);
		pdsum_c = (DATA_W+2)'(dp_c) + (DATA_W+2)'(dd_c);
		pdi_c   = (DATA_W+3)'(pdsum_c) + (DATA_W+3)'(di_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			e1_q <= '0;
			e2_q <= '0;
		end else begin
			if (rdy_s5) v_s5 <= up_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (take_s5) begin
				if (up_item.kind == KIND_CLEAR) begin
					e1_q <= '0;
					e2_q <= '0;
				end else begin
					e1_q <= up_item.err;
					e2_q <= e1_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s5) begin
			kind_s5 <= up_item.kind;
			err_s5  <= up_item.err;
			dpe_s5  <= dpe_c;
			dde_s5  <= dde_c;
		end
		if (v_s5 && rdy_s6) begin
			kind_s6 <= kind_s5;
			err_s6  <= err_s5;
			pp_s6   <= pp_c;
			pi_s6   <= pi_c;
			pd_s6   <= pd_c;
		end
		if (v_s6 && rdy_s7) begin
			item_s7.kind <= kind_s6;
			item_s7.err  <= err_s6;
			item_s7.pd   <= pdsum_c;
			item_s7.pdi  <= pdi_c;
			item_s7.di   <= di_c;
		end
	end

endmodule

`default_nettype wire

>>> hdl/ipid_accum.sv
`default_nettype none

module ipid_accum import ipid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      up_valid,
	output logic      up_ready,
	input  inc_item_t up_item,
	input  cfg_t      cfg,
	output logic      out_valid,
	input  logic      out_stall,
	output out_rsp_t  out_rsp
);

	logic                     valid_q;
	out_rsp_t                 rsp_q;
	logic signed [DATA_W-1:0] int_q, drv_q;
	logic                     take;

	logic signed [DATA_W+4:0] base, aw, sum_x;
	logic                     drop;
	logic signed [DATA_W+1:0] lim, di_a, tmp, di_f;
	logic signed [DATA_W-1:0] int_c, sum_sat, sum_clamp, drv_c;
	logic                     clamp_c;

	assign up_ready  = !valid_q || !out_stall;
	assign take      = up_valid && up_ready;
	assign out_valid = valid_q;
	assign out_rsp   = rsp_q;

	always_comb begin
		base = (DATA_W+5)'(drv_q) + (DATA_W+5)'(up_item.pd);
		aw   = (DATA_W+5)'(drv_q) + (DATA_W+5)'(up_item.pdi);
		// anti-windup drops the integral step when the drive would run past a limit
		drop = (up_item.kind == KIND_ANTIWINDUP) &&
			((up_item.err > 0 && aw > (DATA_W+5)'(cfg.output_max)) ||
			 (up_item.err < 0 && aw < (DATA_W+5)'(cfg.output_min)));
		di_a = drop ? '0 : (DATA_W+2)'(up_item.di);
		lim  = $signed({3'b000, cfg.integ_bound});
		tmp  = (DATA_W+2)'(int_q) + di_a;
		priority if (tmp > lim) begin
			di_f  = lim - (DATA_W+2)'(int_q);
			int_c = DATA_W'(lim);
		end else if (tmp < -lim) begin
			di_f  = -lim - (DATA_W+2)'(int_q);
			int_c = DATA_W'(-lim);
		end else begin
			di_f  = di_a;
			int_c = DATA_W'(tmp);
		end
		sum_x   = base + (DATA_W+5)'(di_f);
		sum_sat = sat32(64'(sum_x));
		// upper bound wins when the sum lies past both limits (inverted limits)
		priority if (sum_sat > cfg.output_max) begin
			sum_clamp = cfg.output_max;
			clamp_c   = 1'b1;
		end else if (sum_sat < cfg.output_min) begin
			sum_clamp = cfg.output_min;
			clamp_c   = 1'b1;
		end else begin
			sum_clamp = sum_sat;
			clamp_c   = 1'b0;
		end
		drv_c = (abs32(sum_clamp) <= {1'b0, cfg.output_zone}) ? '0 : sum_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			int_q   <= '0;
			drv_q   <= '0;
		end else begin
			if (up_ready) valid_q <= up_valid;
			if (take) begin
				if (up_item.kind == KIND_CLEAR) begin
					int_q <= '0;
					drv_q <= '0;
				end else begin
					int_q <= int_c;
					drv_q <= drv_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (up_item.kind == KIND_CLEAR) begin
				rsp_q <= '0;
			end else begin
				rsp_q.drive      <= drv_c;
				rsp_q.error_used <= up_item.err;
				rsp_q.clamped    <= clamp_c;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/incremental_pid_controller_core.sv
// a request passes the error stages, the gain stages and then the accumulator output register
// throughput: one request per cycle while the output is not stalled, set by the integral and drive
// accumulator update in the last stage; stage 5 also keeps the error history, the rest are plain registers
// a stalled result holds its stage while empty stages upstream keep filling
// reset clears all pipeline valids and controller state, and loads the
// register defaults (limits of +-1000.0, gains and deadzones zero)
`default_nettype none

module incremental_pid_controller_core import ipid_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_req_t              in_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_rsp_t             out_rsp
);

	cfg_t      cfg_q;
	logic      err_ready;
	logic      err_valid, gain_ready;
	err_item_t err_item;
	logic      inc_valid, acc_ready;
	inc_item_t inc_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= '0;
			cfg_q.gain_i      <= '0;
			cfg_q.gain_d      <= '0;
			cfg_q.integ_bound <= RST_LIMIT;
			cfg_q.output_max  <= RST_OUT_MAX;
			cfg_q.output_min  <= RST_OUT_MIN;
			cfg_q.error_zone  <= '0;
			cfg_q.output_zone <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:      cfg_q.gain_p      <= cfg_data;
				REG_GAIN_I:      cfg_q.gain_i      <= cfg_data;
				REG_GAIN_D:      cfg_q.gain_d      <= cfg_data;
				REG_INTEG_BOUND: cfg_q.integ_bound <= cfg_data[ZONE_W-1:0];
				REG_OUTPUT_MAX:  cfg_q.output_max  <= cfg_data;
				REG_OUTPUT_MIN:  cfg_q.output_min  <= cfg_data;
				REG_ERROR_ZONE:  cfg_q.error_zone  <= cfg_data[ZONE_W-1:0];
				REG_OUTPUT_ZONE: cfg_q.output_zone <= cfg_data[ZONE_W-1:0];
				default:         cfg_q.gain_p      <= cfg_q.gain_p;
			endcase
		end
	end

	assign in_stall = !err_ready;

	ipid_error u_error (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_ready (err_ready),
		.up_req   (in_req),
		.cfg      (cfg_q),
		.dn_valid (err_valid),
		.dn_ready (gain_ready),
		.dn_item  (err_item)
	);

	ipid_gain u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (err_valid),
		.up_ready (gain_ready),
		.up_item  (err_item),
		.cfg      (cfg_q),
		.dn_valid (inc_valid),
		.dn_ready (acc_ready),
		.dn_item  (inc_item)
	);

	ipid_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (inc_valid),
		.up_ready  (acc_ready),
		.up_item   (inc_item),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp)
	);

	// an empty output register lets every stage move, so requests are never held off
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("request stalled with empty output");

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.clamped) |->
		(out_rsp.drive == cfg_q.output_max || out_rsp.drive == cfg_q.output_min ||
		 out_rsp.drive == '0))
		else $error("clamped drive is not a limit");

	a_output_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.drive != '0) |->
		(abs32(out_rsp.drive) > {1'b0, cfg_q.output_zone}))
		else $error("drive inside output deadzone");

	a_error_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.error_used != '0) |->
		(abs32(out_rsp.error_used) >= {1'b0, cfg_q.error_zone}))
		else $error("error inside error deadzone");

endmodule

`default_nettype wire
